// ===== hdl/ile_pkg.sv =====
// Shared constants, request and status codes, and sequencer state type for the
// indexed list engine. No dependencies.
`default_nettype none
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 7;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] RQ_GET    = 3'd0;
  localparam logic [2:0] RQ_HEAD   = 3'd1;
  localparam logic [2:0] RQ_TAIL   = 3'd2;
  localparam logic [2:0] RQ_INSERT = 3'd3;
  localparam logic [2:0] RQ_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_GET   = 8'b0000_0100,
    S_UP_RD = 8'b0000_1000,
    S_UP_WR = 8'b0001_0000,
    S_PUT   = 8'b0010_0000,
    S_DN_RD = 8'b0100_0000,
    S_DN_WR = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/ile_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/indexed_list_engine_unit.sv =====
// Indexed list engine top level: sequencer, element count and result registers.
// Depends on ile_pkg and ile_ram.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+---------------------------------------
//  request  | start, busy (taken: start&!busy) | in_req_type, in_position, in_item_value
//  result   | out_strobe (one cycle)           | out_read_value, out_found, out_status,
//           |                                  | out_list_length
//
// One transaction at a time; busy is high from acceptance until the result is
// issued. Elements move one place at a time through the single RAM port pair
// (read, then write). The strobe is high in the first cycle back in idle; results
// cannot be stalled. Synchronous active-low reset empties the list.
`default_nettype none
module indexed_list_engine_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_req_type,
  input  wire logic signed [15:0] in_position,
  input  wire logic signed [31:0] in_item_value,
  output logic                    out_strobe,
  output logic signed [31:0]      out_read_value,
  output logic                    out_found,
  output logic [1:0]              out_status,
  output logic [6:0]              out_list_length
);

  ile_pkg::state_t state_r, state_nxt;

  logic [2:0]                   req_r, req_nxt;
  logic signed [ile_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [ile_pkg::DATA_W-1:0]   value_r, value_nxt;
  logic [ile_pkg::ADDR_W-1:0]   idx_r, idx_nxt;
  logic [ile_pkg::ADDR_W-1:0]   slot_r, slot_nxt;
  logic [ile_pkg::CNT_W-1:0]    count_r, count_nxt;

  logic                         strobe_r;
  logic [ile_pkg::DATA_W-1:0]   rv_r;
  logic                         found_r;
  logic [1:0]                   status_r;
  logic [ile_pkg::LEN_W-1:0]    len_r;

  logic                         ram_we;
  logic [ile_pkg::ADDR_W-1:0]   ram_waddr;
  logic [ile_pkg::DATA_W-1:0]   ram_wdata;
  logic [ile_pkg::ADDR_W-1:0]   ram_raddr;
  logic [ile_pkg::DATA_W-1:0]   ram_rdata;

  logic                         fin;
  logic [1:0]                   fin_status;
  logic                         fin_found;
  logic [ile_pkg::DATA_W-1:0]   fin_value;

  logic                         pos_neg;
  logic [ile_pkg::CMP_W-1:0]    pos_u;
  logic [ile_pkg::CMP_W-1:0]    cnt_u;
  logic                         pos_in_range;
  logic                         ins_ok;
  logic [ile_pkg::ADDR_W-1:0]   ins_slot;
  logic [ile_pkg::ADDR_W-1:0]   count_a;
  logic                         list_full;
  logic [ile_pkg::ADDR_W-1:0]   idx_dec;
  logic [ile_pkg::CNT_W:0]      idx_plus2;

  ile_ram #(
    .WIDTH (ile_pkg::DATA_W),
    .DEPTH (ile_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_neg      = pos_r[ile_pkg::POS_W-1];
  assign pos_u        = ile_pkg::CMP_W'(pos_r[ile_pkg::POS_W-2:0]);
  assign cnt_u        = ile_pkg::CMP_W'(count_r);
  assign pos_in_range = !pos_neg && (pos_u < cnt_u);
  assign count_a      = ile_pkg::ADDR_W'(count_r);
  assign list_full    = (count_r == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
  assign idx_dec      = idx_r - ile_pkg::ADDR_W'(1);
  assign idx_plus2    = (ile_pkg::CNT_W + 1)'(idx_r) + (ile_pkg::CNT_W + 1)'(2);

  always_comb begin
    case (req_r)
      ile_pkg::RQ_HEAD: begin
        ins_ok   = 1'b1;
        ins_slot = '0;
      end
      ile_pkg::RQ_TAIL: begin
        ins_ok   = 1'b1;
        ins_slot = count_a;
      end
      ile_pkg::RQ_INSERT: begin
        ins_ok   = pos_neg || (pos_u <= cnt_u);
        ins_slot = pos_neg ? '0 : ile_pkg::ADDR_W'(pos_u);
      end
      default: begin
        ins_ok   = 1'b0;
        ins_slot = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    pos_nxt    = pos_r;
    value_nxt  = value_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_r;
    fin        = 1'b0;
    fin_status = ile_pkg::ST_DONE;
    fin_found  = 1'b0;
    fin_value  = '0;
    case (state_r)
      ile_pkg::S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          pos_nxt   = in_position;
          value_nxt = in_item_value;
          state_nxt = ile_pkg::S_EVAL;
        end
      end
      ile_pkg::S_EVAL: begin
        case (req_r)
          ile_pkg::RQ_GET: begin
            if (pos_in_range) begin
              ram_raddr = ile_pkg::ADDR_W'(pos_u);
              state_nxt = ile_pkg::S_GET;
            end else begin
              fin        = 1'b1;
              fin_status = ile_pkg::ST_IGNORED;
            end
          end
          ile_pkg::RQ_HEAD, ile_pkg::RQ_TAIL, ile_pkg::RQ_INSERT: begin
            if (!ins_ok) begin
              fin        = 1'b1;
              fin_status = ile_pkg::ST_IGNORED;
            end else if (list_full) begin
              fin        = 1'b1;
              fin_status = ile_pkg::ST_FULL;
            end else begin
              slot_nxt  = ins_slot;
              idx_nxt   = count_a;
              state_nxt = (count_a > ins_slot) ? ile_pkg::S_UP_RD : ile_pkg::S_PUT;
            end
          end
          ile_pkg::RQ_DELETE: begin
            if (pos_in_range) begin
              idx_nxt = ile_pkg::ADDR_W'(pos_u);
              if ((pos_u + ile_pkg::CMP_W'(1)) < cnt_u) begin
                state_nxt = ile_pkg::S_DN_RD;
              end else begin
                count_nxt = count_r - ile_pkg::CNT_W'(1);
                fin       = 1'b1;
              end
            end else begin
              fin        = 1'b1;
              fin_status = ile_pkg::ST_IGNORED;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = ile_pkg::ST_IGNORED;
          end
        endcase
      end
      ile_pkg::S_GET: begin
        fin       = 1'b1;
        fin_found = 1'b1;
        fin_value = ram_rdata;
      end
      ile_pkg::S_UP_RD: begin
        ram_raddr = idx_dec;
        state_nxt = ile_pkg::S_UP_WR;
      end
      ile_pkg::S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        idx_nxt   = idx_dec;
        state_nxt = (idx_dec > slot_r) ? ile_pkg::S_UP_RD : ile_pkg::S_PUT;
      end
      ile_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = value_r;
        count_nxt = count_r + ile_pkg::CNT_W'(1);
        fin       = 1'b1;
      end
      ile_pkg::S_DN_RD: begin
        ram_raddr = idx_r + ile_pkg::ADDR_W'(1);
        state_nxt = ile_pkg::S_DN_WR;
      end
      ile_pkg::S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        idx_nxt   = idx_r + ile_pkg::ADDR_W'(1);
        if (idx_plus2 < (ile_pkg::CNT_W + 1)'(count_r)) begin
          state_nxt = ile_pkg::S_DN_RD;
        end else begin
          count_nxt = count_r - ile_pkg::CNT_W'(1);
          fin       = 1'b1;
        end
      end
      default: begin
        state_nxt = ile_pkg::S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = ile_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ile_pkg::S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    pos_r   <= pos_nxt;
    value_r <= value_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    if (fin) begin
      rv_r     <= fin_value;
      found_r  <= fin_found;
      status_r <= fin_status;
      len_r    <= ile_pkg::LEN_W'(count_nxt);
    end
  end

  assign busy            = (state_r != ile_pkg::S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_read_value  = rv_r;
  assign out_found       = found_r;
  assign out_status      = status_r;
  assign out_list_length = len_r;

endmodule
`default_nettype wire

// ===== tb/tb_indexed_list_engine_unit.sv =====
// Self-checking testbench for indexed_list_engine_unit: directed list edge cases,
// a fill to capacity and random insert/delete/get traffic against a shadow list.
// Depends on ile_pkg and the indexed_list_engine_unit RTL.
`timescale 1ns / 1ps

module tb_indexed_list_engine_unit;

  localparam logic [2:0] RQ_RSVD_LO  = 3'd5;
  localparam logic [2:0] RQ_RSVD_HI  = 3'd7;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         DRAIN_WAIT  = 150;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [1:0]         status;
    logic [6:0]         list_length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_req_type;
  logic signed [15:0] in_position;
  logic signed [31:0] in_item_value;
  logic out_strobe;
  logic signed [31:0] out_read_value;
  logic out_found;
  logic [1:0] out_status;
  logic [6:0] out_list_length;

  logic signed [31:0] shadow_list[$];
  list_result_t pending_results[$];
  list_result_t oldest_result;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  int sender_idle_pct = 0;
  bit growing = 1'b1;

  indexed_list_engine_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_item_value(in_item_value),
    .out_strobe(out_strobe),
    .out_read_value(out_read_value),
    .out_found(out_found),
    .out_status(out_status),
    .out_list_length(out_list_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("** indexed_list_engine_unit: FAILED **");
      $finish;
    end
  end

  function automatic logic [1:0] store_at(input int slot, input logic signed [31:0] value);
    if (shadow_list.size() >= ile_pkg::CAPACITY) return ile_pkg::ST_FULL;
    shadow_list.insert(slot, value);
    return ile_pkg::ST_DONE;
  endfunction

  function automatic list_result_t apply_to_shadow_list(input logic [2:0] kind,
                                                        input logic signed [15:0] pos,
                                                        input logic signed [31:0] value);
    list_result_t res;
    int p;
    int len;
    p = pos;
    len = shadow_list.size();
    res = '0;
    res.status = ile_pkg::ST_IGNORED;
    case (kind)
      ile_pkg::RQ_GET: begin
        if (p >= 0 && p < len) begin
          res.read_value = shadow_list[p];
          res.found = 1'b1;
          res.status = ile_pkg::ST_DONE;
        end
      end
      ile_pkg::RQ_HEAD: res.status = store_at(0, value);
      ile_pkg::RQ_TAIL: res.status = store_at(len, value);
      ile_pkg::RQ_INSERT: begin
        if (p <= 0) res.status = store_at(0, value);
        else if (p <= len) res.status = store_at(p, value);
      end
      ile_pkg::RQ_DELETE: begin
        if (p >= 0 && p < len) begin
          shadow_list.delete(p);
          res.status = ile_pkg::ST_DONE;
        end
      end
      default: res.status = ile_pkg::ST_IGNORED;
    endcase
    res.list_length = 7'(shadow_list.size());
    return res;
  endfunction

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic send_request(input logic [2:0] kind, input logic signed [15:0] pos,
                              input logic signed [31:0] value);
    if ($urandom_range(0, 99) < sender_idle_pct) pause_sender($urandom_range(1, 6));
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= kind;
    in_position <= pos;
    in_item_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_to_shadow_list(kind, pos, value));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input longint expected_v,
                                 input longint actual_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected_v, actual_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction outstanding", $time);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_read_value !== oldest_result.read_value)
          report_mismatch("read_value", oldest_result.read_value, out_read_value);
        if (out_found !== oldest_result.found)
          report_mismatch("found", oldest_result.found, out_found);
        if (out_status !== oldest_result.status)
          report_mismatch("status", oldest_result.status, out_status);
        if (out_list_length !== oldest_result.list_length)
          report_mismatch("list_length", oldest_result.list_length, out_list_length);
      end
    end
  end

  function automatic logic signed [15:0] pick_position(input int len);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 16'($urandom_range(0, len));
    if (pick == 7) return 16'(len + int'($urandom_range(1, 3)));
    if (pick == 8) return 16'(-int'($urandom_range(1, 3)));
    return 16'($urandom());
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_list_edges();
    send_request(ile_pkg::RQ_GET, 0, 0);
    send_request(ile_pkg::RQ_GET, -32768, 0);
    send_request(ile_pkg::RQ_DELETE, 0, 0);
    send_request(ile_pkg::RQ_INSERT, 1, 32'sh1234_5678);
    send_request(ile_pkg::RQ_INSERT, 32767, 32'sh1234_5678);
    for (int k = RQ_RSVD_LO; k <= RQ_RSVD_HI; k++) send_request(3'(k), 0, -32'sd1);
    send_request(ile_pkg::RQ_HEAD, 0, 32'sh7FFF_FFFF);
    send_request(ile_pkg::RQ_TAIL, -1, 32'sh8000_0000);
    send_request(ile_pkg::RQ_INSERT, -32768, -32'sd1);
    send_request(ile_pkg::RQ_INSERT, 3, 32'sd0);
    send_request(ile_pkg::RQ_INSERT, 2, 32'sd12345);
    send_request(ile_pkg::RQ_GET, 0, 0);
    send_request(ile_pkg::RQ_GET, 4, 0);
    send_request(ile_pkg::RQ_GET, 5, 0);
    send_request(ile_pkg::RQ_GET, 32767, 0);
    send_request(ile_pkg::RQ_GET, -1, 0);
    send_request(ile_pkg::RQ_DELETE, -1, 0);
    send_request(ile_pkg::RQ_DELETE, 5, 0);
    send_request(ile_pkg::RQ_DELETE, 4, 0);
    send_request(ile_pkg::RQ_DELETE, 0, 0);
    send_request(ile_pkg::RQ_DELETE, 1, 0);
  endtask

  task automatic test_full_list();
    logic [2:0] kind;
    while (shadow_list.size() < ile_pkg::CAPACITY) begin
      kind = 3'($urandom_range(ile_pkg::RQ_HEAD, ile_pkg::RQ_INSERT));
      send_request(kind, pick_position(shadow_list.size()), pick_value());
    end
    send_request(ile_pkg::RQ_HEAD, 0, pick_value());
    send_request(ile_pkg::RQ_TAIL, 0, pick_value());
    send_request(ile_pkg::RQ_INSERT, 10, pick_value());
    send_request(ile_pkg::RQ_INSERT, -5, pick_value());
    send_request(ile_pkg::RQ_INSERT, 16'(ile_pkg::CAPACITY), pick_value());
    // beyond the end wins over full
    send_request(ile_pkg::RQ_INSERT, 16'(ile_pkg::CAPACITY + 1), pick_value());
    send_request(ile_pkg::RQ_GET, 16'(ile_pkg::CAPACITY - 1), 0);
    send_request(ile_pkg::RQ_GET, 16'(ile_pkg::CAPACITY), 0);
    send_request(ile_pkg::RQ_DELETE, 16'(ile_pkg::CAPACITY), 0);
    send_request(ile_pkg::RQ_DELETE, 16'(ile_pkg::CAPACITY - 1), 0);
    send_request(ile_pkg::RQ_INSERT, 16'(ile_pkg::CAPACITY - 1), pick_value());
    send_request(ile_pkg::RQ_GET, 16'(ile_pkg::CAPACITY - 1), 0);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    logic [2:0] kind;
    int pick;
    int len;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      len = shadow_list.size();
      if (len == ile_pkg::CAPACITY && $urandom_range(0, 99) < 15) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) == 0) growing = !growing;
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = 3'($urandom_range(RQ_RSVD_LO, RQ_RSVD_HI));
      else if (pick < 20) kind = ile_pkg::RQ_GET;
      else if (pick < (growing ? 75 : 45))
        kind = 3'($urandom_range(ile_pkg::RQ_HEAD, ile_pkg::RQ_INSERT));
      else kind = ile_pkg::RQ_DELETE;
      send_request(kind, pick_position(len), pick_value());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = ile_pkg::RQ_GET;
    in_position = '0;
    in_item_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list_edges();
    test_full_list();
    hold_until_drained();
    test_random_traffic(430, 38);
    hold_until_drained();
    test_random_traffic(430, 72);
    hold_until_drained();
    test_random_traffic(440, 0);

    hold_until_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** indexed_list_engine_unit: PASSED **");
    end else begin
      $display("** indexed_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
